[rtl/bgsa_pkg.sv]
// Shared types, codes and defaults for the banded glocal sequence aligner.
package bgsa_pkg;

    localparam int DEF_MAX_LEN  = 1024;
    localparam int DEF_MAX_BAND = 32;

    localparam logic [7:0] GAP_SYM = 8'd45;

    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_ALIGN       = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    localparam logic [1:0] STAT_COLUMN = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_NARROW = 2'd2;

    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    localparam logic [1:0] MV_LEFT = 2'd0;
    localparam logic [1:0] MV_UP   = 2'd1;
    localparam logic [1:0] MV_DIAG = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] symbol;
        logic [5:0] band_width;
    } item_t;

    typedef struct packed {
        logic [7:0] first_column;
        logic [7:0] second_column;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_FIRST,
        OP_LOAD_SECOND,
        OP_ALIGN,
        OP_ZERO,
        OP_ROW_INIT,
        OP_CELL_RD0,
        OP_CELL_RD1,
        OP_CELL_RD2,
        OP_CELL_CALC,
        OP_ROW_NEXT,
        OP_WALK_INIT,
        OP_WALK_CHECK,
        OP_WALK_MOVE,
        OP_WALK_WRITE,
        OP_FINISH,
        OP_NARROW,
        OP_RD_ISSUE,
        OP_RD_OUT
    } dp_op_t;

    typedef struct packed {
        logic too_narrow;
        logic zero_last;
        logic row_empty;
        logic rows_done;
        logic cell_last;
        logic walk_stop;
        logic move_brk;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/bgsa_dp.sv]
// Datapath: sequence stores, score rows, trace matrix, path buffer and result register.
module bgsa_dp
    import bgsa_pkg::*;
#(
    parameter int MAX_LEN  = DEF_MAX_LEN,
    parameter int MAX_BAND = DEF_MAX_BAND
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_op_t      op,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output dp_status_t  sts,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int NCOLS  = 2 * MAX_BAND + 1;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int AW     = $clog2(MAX_LEN);
    localparam int BW     = $clog2(MAX_BAND + 1);
    localparam int CW     = $clog2(MAX_LEN + 2 * MAX_BAND + 2) + 2;
    localparam int SW     = $clog2(2 * MAX_LEN) + 9;
    localparam int SDEPTH = 2 * NCOLS;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int TDEPTH = (MAX_LEN + 1) * NCOLS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int PDEPTH = 2 * MAX_LEN;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int PCW    = $clog2(PDEPTH + 1);

    localparam logic signed [CW-1:0] C_ZERO  = CW'(0);
    localparam logic signed [CW-1:0] C_ONE   = CW'(1);
    localparam logic signed [CW-1:0] C_NCOLS = CW'(NCOLS);

    logic signed [7:0]     match_reg, mismatch_reg, gap_reg;
    logic [LW-1:0]         first_len_reg, second_len_reg;
    logic [BW-1:0]         band_reg;
    logic signed [CW-1:0]  i_reg, j_reg, hi_reg;
    logic [TAW-1:0]        rowbase_reg;
    logic                  bank_reg;
    logic [7:0]            a_rd_reg, b_rd_reg;

    logic [7:0]            first_mem  [MAX_LEN];
    logic [7:0]            second_mem [MAX_LEN];
    logic signed [SW-1:0]  score_mem  [SDEPTH];
    logic [1:0]            trace_mem  [TDEPTH];
    logic [15:0]           path_mem   [PDEPTH];

    logic signed [SW-1:0]  score_q_reg;
    logic                  score_vq_reg;
    logic [SDEPTH-1:0]     score_vld_reg;
    logic signed [SW-1:0]  pr_j_reg, diag_reg, up_reg;
    logic [1:0]            trace_q_reg, mv_reg;
    logic [15:0]           path_q_reg;
    logic [PCW-1:0]        path_count_reg, rd_ptr_reg;
    logic                  rd_hit_reg, rd_last_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic signed [CW-1:0]  b_s, nc_s, l1_s, l2_s, t_s, lo_s, hi_s, bnd_s, jp1_s, jm1_s;
    logic signed [SW-1:0]  score_rd, left_s, best_s, up_gap, left_gap, sub_s;
    logic [1:0]            best_mv;
    logic                  score_re, score_we;
    logic [SAW-1:0]        score_ra, score_wa;
    logic                  trace_we;
    logic [TAW-1:0]        trace_wa;
    logic [1:0]            trace_wd;
    logic                  move_brk;
    logic [7:0]            walk_a, walk_c;
    logic                  out_free;

    function automatic logic [SAW-1:0] sc_addr(input logic bank, input logic signed [CW-1:0] jj);
        logic signed [CW-1:0] full;
        begin
            full = jj + (bank ? C_NCOLS : C_ZERO);
            return SAW'(full);
        end
    endfunction

    assign b_s   = signed'(CW'(band_reg));
    assign nc_s  = b_s + b_s + C_ONE;
    assign l1_s  = signed'(CW'(first_len_reg));
    assign l2_s  = signed'(CW'(second_len_reg));
    assign t_s   = j_reg + i_reg - b_s;
    assign jp1_s = (j_reg + C_ONE >= C_NCOLS) ? j_reg : j_reg + C_ONE;
    assign jm1_s = (j_reg > C_ZERO) ? j_reg - C_ONE : C_ZERO;

    always_comb
    begin
        lo_s  = b_s - i_reg + C_ONE;
        if (lo_s < C_ZERO)
        begin
            lo_s = C_ZERO;
        end
        hi_s = b_s + C_ONE - i_reg + l2_s;
        if (hi_s > nc_s)
        begin
            hi_s = nc_s;
        end
        bnd_s = b_s - i_reg;
        if (bnd_s < C_ZERO)
        begin
            bnd_s = C_ZERO;
        end
    end

    assign score_rd = score_vq_reg ? score_q_reg : '0;
    assign out_free = !result_valid_reg || !result_stall;

    // Cell recurrence: diagonal first, then up, then left on strict gain
    always_comb
    begin
        sub_s    = (a_rd_reg == b_rd_reg) ? SW'(match_reg) : SW'(mismatch_reg);
        up_gap   = (t_s == l2_s) ? SW'(C_ZERO) : SW'(gap_reg);
        left_gap = (i_reg == l1_s) ? SW'(C_ZERO) : SW'(gap_reg);
        left_s   = score_rd + left_gap;
        best_s   = diag_reg;
        best_mv  = MV_DIAG;
        if ((j_reg < nc_s - C_ONE) && (up_reg > best_s))
        begin
            best_s  = up_reg;
            best_mv = MV_UP;
        end
        if ((j_reg > C_ZERO) && (left_s > best_s))
        begin
            best_s  = left_s;
            best_mv = MV_LEFT;
        end
    end

    always_comb
    begin
        score_re = 1'b0;
        score_ra = sc_addr(bank_reg, j_reg);
        unique case (op)
            OP_CELL_RD0:
            begin
                score_re = 1'b1;
            end
            OP_CELL_RD1:
            begin
                score_re = 1'b1;
                score_ra = sc_addr(bank_reg, jp1_s);
            end
            OP_CELL_RD2:
            begin
                score_re = 1'b1;
                score_ra = sc_addr(!bank_reg, jm1_s);
            end
            default:
            begin
                score_re = 1'b0;
            end
        endcase
    end

    assign score_we = (op == OP_CELL_CALC);
    assign score_wa = sc_addr(!bank_reg, j_reg);

    always_comb
    begin
        trace_we = 1'b0;
        trace_wa = rowbase_reg + TAW'(j_reg);
        trace_wd = best_mv;
        unique case (op)
            OP_ZERO:
            begin
                trace_we = 1'b1;
                trace_wa = TAW'(j_reg);
                trace_wd = MV_LEFT;
            end
            OP_ROW_INIT:
            begin
                trace_we = 1'b1;
                trace_wa = rowbase_reg + TAW'(bnd_s);
                trace_wd = MV_UP;
            end
            OP_CELL_CALC:
            begin
                trace_we = 1'b1;
            end
            default:
            begin
                trace_we = 1'b0;
            end
        endcase
    end

    // Legality of the traceback move just read
    always_comb
    begin
        unique case (trace_q_reg)
            MV_UP:   move_brk = (i_reg < C_ONE) || (j_reg + C_ONE >= nc_s);
            MV_LEFT: move_brk = (t_s < C_ONE) || (t_s > l2_s) || (j_reg < C_ONE);
            default: move_brk = (i_reg < C_ONE) || (t_s < C_ONE) || (t_s > l2_s);
        endcase
    end

    always_comb
    begin
        unique case (mv_reg)
            MV_UP:
            begin
                walk_a = a_rd_reg;
                walk_c = GAP_SYM;
            end
            MV_LEFT:
            begin
                walk_a = GAP_SYM;
                walk_c = b_rd_reg;
            end
            default:
            begin
                walk_a = a_rd_reg;
                walk_c = b_rd_reg;
            end
        endcase
    end

    assign sts.too_narrow = (l2_s - l1_s > b_s) || (l1_s - l2_s > b_s);
    assign sts.zero_last  = (j_reg + C_ONE >= nc_s);
    assign sts.row_empty  = (lo_s >= hi_s);
    assign sts.rows_done  = (i_reg > l1_s);
    assign sts.cell_last  = (j_reg + C_ONE >= hi_reg);
    assign sts.walk_stop  = ((i_reg == C_ZERO) && (j_reg == b_s))
                          || (path_count_reg >= PCW'(PDEPTH))
                          || (j_reg < C_ZERO) || (j_reg >= nc_s);
    assign sts.move_brk   = move_brk;
    assign sts.out_free   = out_free;

    // Memories
    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD_FIRST && first_len_reg < LW'(MAX_LEN))
        begin
            first_mem[AW'(first_len_reg)] <= item.symbol;
        end
        if (op == OP_LOAD_SECOND && second_len_reg < LW'(MAX_LEN))
        begin
            second_mem[AW'(second_len_reg)] <= item.symbol;
        end
        if (op == OP_ROW_INIT || op == OP_WALK_MOVE)
        begin
            a_rd_reg <= first_mem[AW'(i_reg - C_ONE)];
        end
        if (op == OP_CELL_RD0 || op == OP_WALK_MOVE)
        begin
            b_rd_reg <= second_mem[AW'(t_s - C_ONE)];
        end
        if (score_we)
        begin
            score_mem[score_wa] <= best_s;
        end
        if (score_re)
        begin
            score_q_reg <= score_mem[score_ra];
        end
        if (trace_we)
        begin
            trace_mem[trace_wa] <= trace_wd;
        end
        if (op == OP_WALK_CHECK)
        begin
            trace_q_reg <= trace_mem[rowbase_reg + TAW'(j_reg)];
        end
        if (op == OP_WALK_WRITE)
        begin
            path_mem[PAW'(path_count_reg)] <= {walk_a, walk_c};
        end
        if (op == OP_RD_ISSUE)
        begin
            path_q_reg <= path_mem[PAW'(path_count_reg - PCW'(1) - rd_ptr_reg)];
        end
    end

    // Working registers of the sweep and the walk
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_ALIGN:
            begin
                if (int'(item.band_width) > MAX_BAND)
                begin
                    band_reg <= BW'(MAX_BAND);
                end
                else
                begin
                    band_reg <= BW'(item.band_width);
                end
                i_reg       <= C_ONE;
                j_reg       <= C_ZERO;
                rowbase_reg <= TAW'(NCOLS);
                bank_reg    <= 1'b0;
            end
            OP_ZERO:
            begin
                j_reg <= j_reg + C_ONE;
            end
            OP_ROW_INIT:
            begin
                j_reg  <= lo_s;
                hi_reg <= hi_s;
            end
            OP_CELL_RD1:
            begin
                pr_j_reg <= score_rd;
            end
            OP_CELL_RD2:
            begin
                diag_reg <= pr_j_reg + sub_s;
                up_reg   <= score_rd + up_gap;
            end
            OP_CELL_CALC:
            begin
                j_reg <= j_reg + C_ONE;
            end
            OP_ROW_NEXT:
            begin
                i_reg       <= i_reg + C_ONE;
                bank_reg    <= !bank_reg;
                rowbase_reg <= rowbase_reg + TAW'(NCOLS);
            end
            OP_WALK_INIT:
            begin
                i_reg       <= i_reg - C_ONE;
                j_reg       <= b_s + l2_s - l1_s;
                rowbase_reg <= rowbase_reg - TAW'(NCOLS);
            end
            OP_WALK_MOVE:
            begin
                mv_reg <= trace_q_reg;
            end
            OP_WALK_WRITE:
            begin
                unique case (mv_reg)
                    MV_UP:
                    begin
                        i_reg       <= i_reg - C_ONE;
                        j_reg       <= j_reg + C_ONE;
                        rowbase_reg <= rowbase_reg - TAW'(NCOLS);
                    end
                    MV_LEFT:
                    begin
                        j_reg <= j_reg - C_ONE;
                    end
                    default:
                    begin
                        i_reg       <= i_reg - C_ONE;
                        rowbase_reg <= rowbase_reg - TAW'(NCOLS);
                    end
                endcase
            end
            OP_RD_ISSUE:
            begin
                rd_hit_reg  <= (rd_ptr_reg < path_count_reg);
                rd_last_reg <= (rd_ptr_reg + PCW'(1) == path_count_reg);
            end
            default:
            begin
                mv_reg <= mv_reg;
            end
        endcase
    end

    // Control state: lengths, counts, row valid bits, registers and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg        <= 8'sd5;
            mismatch_reg     <= -8'sd5;
            gap_reg          <= -8'sd3;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            path_count_reg   <= '0;
            rd_ptr_reg       <= '0;
            score_vld_reg    <= '0;
            score_vq_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MATCH:    match_reg    <= signed'(cfg_data);
                    CFG_MISMATCH: mismatch_reg <= signed'(cfg_data);
                    CFG_GAP:      gap_reg      <= signed'(cfg_data);
                    default:      gap_reg      <= gap_reg;
                endcase
            end
            if (score_re)
            begin
                score_vq_reg <= score_vld_reg[score_ra];
            end
            if (result_valid_reg && !result_stall && op != OP_RD_OUT && op != OP_NARROW)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_LOAD_FIRST:
                begin
                    if (first_len_reg < LW'(MAX_LEN))
                    begin
                        first_len_reg <= first_len_reg + LW'(1);
                    end
                end
                OP_LOAD_SECOND:
                begin
                    if (second_len_reg < LW'(MAX_LEN))
                    begin
                        second_len_reg <= second_len_reg + LW'(1);
                    end
                end
                OP_ALIGN:
                begin
                    score_vld_reg  <= '0;
                    path_count_reg <= '0;
                    rd_ptr_reg     <= '0;
                end
                OP_CELL_CALC:
                begin
                    score_vld_reg[score_wa] <= 1'b1;
                end
                OP_WALK_WRITE:
                begin
                    path_count_reg <= path_count_reg + PCW'(1);
                end
                OP_FINISH:
                begin
                    first_len_reg  <= '0;
                    second_len_reg <= '0;
                end
                OP_NARROW:
                begin
                    first_len_reg    <= '0;
                    second_len_reg   <= '0;
                    result_valid_reg <= 1'b1;
                    result_reg       <= '{first_column: 8'd0, second_column: 8'd0,
                                          status: STAT_NARROW, last: 1'b0};
                end
                OP_RD_ISSUE:
                begin
                    if (rd_ptr_reg < path_count_reg)
                    begin
                        rd_ptr_reg <= rd_ptr_reg + PCW'(1);
                    end
                end
                OP_RD_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    if (rd_hit_reg)
                    begin
                        result_reg <= '{first_column: path_q_reg[15:8],
                                        second_column: path_q_reg[7:0],
                                        status: STAT_COLUMN, last: rd_last_reg};
                    end
                    else
                    begin
                        result_reg <= '{first_column: 8'd0, second_column: 8'd0,
                                        status: STAT_EMPTY, last: 1'b0};
                    end
                end
                default:
                begin
                    rd_ptr_reg <= rd_ptr_reg;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (path_count_reg <= PCW'(PDEPTH)) && (rd_ptr_reg <= path_count_reg))
        else $error("path pointer beyond path count");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LW'(MAX_LEN)) && (second_len_reg <= LW'(MAX_LEN)))
        else $error("sequence length beyond store");

    a_cell_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CELL_CALC) |-> ((j_reg >= C_ZERO) && (j_reg < hi_reg) && (j_reg < nc_s)))
        else $error("cell outside band");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_RD_OUT || op == OP_NARROW) |-> out_free)
        else $error("result loaded over a held transfer");

endmodule

[rtl/bgsa_ctrl.sv]
// Controller: sequences loads, the banded sweep, the traceback and column reads.
module bgsa_ctrl
    import bgsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_cmd,
    output logic       item_stall,
    input  dp_status_t sts,
    output dp_op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_NARROW,
        S_ZERO,
        S_ROW_CHK,
        S_ROW_INIT,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_ROW_NEXT,
        S_W_INIT,
        S_W_CHK,
        S_W_MV,
        S_W_WR,
        S_RD_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   finish;

    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_cmd)
                        CMD_LOAD_FIRST:  op = OP_LOAD_FIRST;
                        CMD_LOAD_SECOND: op = OP_LOAD_SECOND;
                        CMD_ALIGN:
                        begin
                            op         = OP_ALIGN;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            op         = OP_RD_ISSUE;
                            state_next = S_RD_OUT;
                        end
                    endcase
                end
            end
            S_CHECK:    state_next = sts.too_narrow ? S_NARROW : S_ZERO;
            S_NARROW:
            begin
                if (sts.out_free)
                begin
                    op         = OP_NARROW;
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                op = OP_ZERO;
                if (sts.zero_last)
                begin
                    state_next = S_ROW_CHK;
                end
            end
            S_ROW_CHK:  state_next = sts.rows_done ? S_W_INIT : S_ROW_INIT;
            S_ROW_INIT:
            begin
                op         = OP_ROW_INIT;
                state_next = sts.row_empty ? S_ROW_NEXT : S_C0;
            end
            S_C0:
            begin
                op         = OP_CELL_RD0;
                state_next = S_C1;
            end
            S_C1:
            begin
                op         = OP_CELL_RD1;
                state_next = S_C2;
            end
            S_C2:
            begin
                op         = OP_CELL_RD2;
                state_next = S_C3;
            end
            S_C3:
            begin
                op         = OP_CELL_CALC;
                state_next = sts.cell_last ? S_ROW_NEXT : S_C0;
            end
            S_ROW_NEXT:
            begin
                op         = OP_ROW_NEXT;
                state_next = S_ROW_CHK;
            end
            S_W_INIT:
            begin
                op         = OP_WALK_INIT;
                state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (sts.walk_stop)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    op         = OP_WALK_CHECK;
                    state_next = S_W_MV;
                end
            end
            S_W_MV:
            begin
                if (sts.move_brk)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    op         = OP_WALK_MOVE;
                    state_next = S_W_WR;
                end
            end
            S_W_WR:
            begin
                op         = OP_WALK_WRITE;
                state_next = S_W_CHK;
            end
            S_RD_OUT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_RD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (finish)
        begin
            op         = OP_FINISH;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && item_valid && item_cmd == CMD_ALIGN) |=> (state_reg == S_CHECK))
        else $error("align transfer not started");

    a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && item_valid && item_cmd == CMD_READ) |=> (state_reg == S_RD_OUT))
        else $error("read transfer not followed by output");

    a_cell_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C0) |=> (state_reg == S_C1) ##1 (state_reg == S_C2))
        else $error("cell sequence broken");

endmodule

[rtl/banded_glocal_sequence_aligner.sv]
// Top level of the banded glocal sequence aligner.
//
// Usage: one input channel (item_valid / item_stall / item) carries commands.
// Load commands write one symbol of the first or second sequence; symbols
// beyond MAX_LEN are dropped. An align command runs a banded linear-gap
// alignment with free end gaps over 2*band+1 diagonals: a sweep over the
// 2*band+1 entries clears trace row zero, then each row visits its banded
// cells, each with three score-row reads and one update on the single
// score-row port, and each traceback column takes a trace read, a symbol
// read and a path write. Each read command does a path buffer read, then a
// result register load. Results leave through the output channel
// (result_valid / result_stall / result), one transfer per read, plus a
// status transfer when the band is too narrow. The result register holds a
// stalled transfer; the block then waits before loading the next one and
// stalls its input meanwhile. Reset clears lengths, the path and the score
// registers (match 5, mismatch -5, gap -3); the sequence stores and the
// trace matrix are not cleared. Configuration writes are registered.
module banded_glocal_sequence_aligner
    import bgsa_pkg::*;
#(
    parameter int MAX_LEN  = DEF_MAX_LEN,
    parameter int MAX_BAND = DEF_MAX_BAND
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Command and status bundles between the sequencer and the datapath
    dp_op_t     op;
    dp_status_t sts;

    // Sequencer: accepts a transfer only when idle, steps the align phases
    bgsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .sts        (sts),
        .op         (op)
    );

    // Datapath: stores, score rows, trace matrix, path buffer, result register
    bgsa_dp #(
        .MAX_LEN  (MAX_LEN),
        .MAX_BAND (MAX_BAND)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
